FILE: design/hdtc_pkg.sv
`default_nettype none

package hdtc_pkg;

   // Default width of the token accumulator.
   localparam int DEFAULT_VALUE_BITS = 32;

   // At most this many characters leave the block for one token.
   localparam int MAX_CHARS = 10;

   // ASCII codes used by the parser and the text generator.
   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_NINE  = 8'd57;
   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] ASCII_LOWER_X = 8'd120;
   localparam logic [7:0] ASCII_MINUS = 8'd45;
   localparam logic [7:0] ASCII_PLUS  = 8'd43;

   // Letters map to ten and up through this bias.
   localparam logic [7:0] HEX_LETTER_BIAS = 8'd55;

   // Commands to the digit unit.
   localparam logic [1:0] DU_HOLD   = 2'd0;
   localparam logic [1:0] DU_LOAD   = 2'd1;
   localparam logic [1:0] DU_DABBLE = 2'd2;
   localparam logic [1:0] DU_SHIFT  = 2'd3;

   // Per-token parser flags.
   typedef struct packed {
      logic [1:0] pos;
      logic       first_zero;
      logic       hex_mode;
      logic       dec_done;
   } token_type;

   // Command bundle from the sequencer to the digit unit.
   typedef struct packed {
      logic [1:0] op;
      logic       serial_bit;
   } du_cmd_type;

endpackage

`default_nettype wire

FILE: design/hdtc_stream_if.sv
`default_nettype none

// Input character channel.
interface hdtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_token;

   modport source (output valid, output in_char, output end_of_token, input ready);
   modport sink   (input valid, input in_char, input end_of_token, output ready);
endinterface

// Output text channel.
interface hdtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

FILE: design/hdtc_char_decode.sv
`default_nettype none

module hdtc_char_decode #(
   parameter int VALUE_BITS = hdtc_pkg::DEFAULT_VALUE_BITS
) (
   input  wire logic [7:0]            in_char,
   input  wire hdtc_pkg::token_type   tok,
   input  wire logic [VALUE_BITS-1:0] acc,
   output hdtc_pkg::token_type        tok_next,
   output logic [VALUE_BITS-1:0]      acc_next,
   output logic                       is_halt
);

   logic is_letter;
   logic is_digit;
   logic [VALUE_BITS-1:0] bias;

   assign is_letter = (in_char >= hdtc_pkg::ASCII_UPPER_A) && (in_char <= hdtc_pkg::ASCII_UPPER_Z);
   assign is_digit  = (in_char >= hdtc_pkg::ASCII_ZERO) && (in_char <= hdtc_pkg::ASCII_NINE);
   assign bias      = is_letter ? VALUE_BITS'(hdtc_pkg::HEX_LETTER_BIAS)
                                : VALUE_BITS'(hdtc_pkg::ASCII_ZERO);

   // A minus sign in the first position stops the block.
   assign is_halt = (tok.pos == 2'd0) && (in_char == hdtc_pkg::ASCII_MINUS);

   // Fold one character into the accumulator and advance the token flags.
   always_comb begin
      tok_next = tok;
      acc_next = acc;
      if (tok.hex_mode) begin
         acc_next = (acc << 4) + VALUE_BITS'(in_char) - bias;
      end else if ((tok.pos == 2'd1) && tok.first_zero && (in_char == hdtc_pkg::ASCII_LOWER_X)) begin
         tok_next.hex_mode = 1'b1;
         acc_next = '0;
      end else if (!tok.dec_done) begin
         if ((tok.pos == 2'd0) && (in_char == hdtc_pkg::ASCII_PLUS)) begin
            acc_next = acc;
         end else if (is_digit) begin
            acc_next = (acc << 3) + (acc << 1)
                       + VALUE_BITS'(in_char) - VALUE_BITS'(hdtc_pkg::ASCII_ZERO);
         end else begin
            tok_next.dec_done = 1'b1;
         end
      end
      if (tok.pos == 2'd0) begin
         tok_next.first_zero = (in_char == hdtc_pkg::ASCII_ZERO);
      end
      if (tok.pos != 2'd3) begin
         tok_next.pos = tok.pos + 2'd1;
      end
   end

endmodule

`default_nettype wire

FILE: design/hdtc_digit_unit.sv
`default_nettype none

module hdtc_digit_unit #(
   parameter int DIGITS = hdtc_pkg::MAX_CHARS
) (
   input  wire logic                  clock,
   input  wire hdtc_pkg::du_cmd_type  cmd,
   input  wire logic [4*DIGITS-1:0]   load_value,
   output logic [3:0]                 top_digit
);

   localparam int DIG_W = 4 * DIGITS;

   logic [DIG_W-1:0] digit_ff;
   logic [DIG_W-1:0] digit_in;
   logic [DIG_W-1:0] adj;

   // Add three to every digit of five or more before the doubling shift.
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         adj[4*k +: 4] = (digit_ff[4*k +: 4] >= 4'd5) ? digit_ff[4*k +: 4] + 4'd3
                                                      : digit_ff[4*k +: 4];
      end
   end

   // One operation per cycle: hold, load, one double-dabble step, or a digit shift.
   always_comb begin
      case (cmd.op)
         hdtc_pkg::DU_LOAD:   digit_in = load_value;
         hdtc_pkg::DU_DABBLE: digit_in = {adj[DIG_W-2:0], cmd.serial_bit};
         hdtc_pkg::DU_SHIFT:  digit_in = {digit_ff[DIG_W-5:0], 4'd0};
         default:             digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign top_digit = digit_ff[DIG_W-1 -: 4];

endmodule

`default_nettype wire

FILE: design/hex_decimal_text_converter_unit.sv
`default_nettype none

// Channel   Dir  Payload                    Beat taken when
// req_chan  in   in_char[7:0], end_of_token valid && ready
// rsp_chan  out  out_char[7:0], last_char   valid && ready
//
// A character that does not end its token is folded into the accumulator.
// A final character of a decimal token starts a leading-zero scan over up to
// DEC_DIGITS digits and then emits its text one beat per character; a hex token
// first runs VALUE_BITS double-dabble steps, one bit per cycle through the digit unit.
// Reset is synchronous and needs no clearing pass. A stalled output beat holds
// the sequencer; req ready is high only while no conversion is running.
module hex_decimal_text_converter_unit #(
   parameter int VALUE_BITS = hdtc_pkg::DEFAULT_VALUE_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   hdtc_req_if.sink   req_chan,
   hdtc_rsp_if.source rsp_chan
);

   localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int DIG_W      = 4 * DEC_DIGITS;
   localparam int CNT_W      = $clog2(VALUE_BITS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DABBLE = 3'd1;
   localparam logic [2:0] ST_SKIP   = 3'd2;
   localparam logic [2:0] ST_PRE0   = 3'd3;
   localparam logic [2:0] ST_PREX   = 3'd4;
   localparam logic [2:0] ST_DIGITS = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   hdtc_pkg::token_type tok_ff, tok_in;
   logic halted_ff, halted_in;
   logic conv_hex_ff, conv_hex_in;
   logic nz_ff, nz_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic last_char_ff, last_char_in;

   hdtc_pkg::token_type tok_next;
   logic [VALUE_BITS-1:0] acc_next;
   logic is_halt;
   hdtc_pkg::du_cmd_type du_cmd;
   logic [DIG_W-1:0] du_load;
   logic [3:0] top_digit;
   logic [7:0] digit_char;
   logic req_beat;
   logic can_load;
   logic top_nz;

   hdtc_char_decode #(.VALUE_BITS(VALUE_BITS)) u_decode (
      .in_char  (req_chan.in_char),
      .tok      (tok_ff),
      .acc      (acc_ff),
      .tok_next (tok_next),
      .acc_next (acc_next),
      .is_halt  (is_halt)
   );

   hdtc_digit_unit #(.DIGITS(DEC_DIGITS)) u_digits (
      .clock      (clock),
      .cmd        (du_cmd),
      .load_value (du_load),
      .top_digit  (top_digit)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign can_load       = !rsp_valid_ff || rsp_chan.ready;
   assign top_nz         = (top_digit != 4'd0);
   assign digit_char     = (top_digit > 4'd9) ? {4'd0, top_digit} + hdtc_pkg::HEX_LETTER_BIAS
                                              : {4'd0, top_digit} + hdtc_pkg::ASCII_ZERO;

   // Sequencer: parse characters, run the dabble, scan and emit the text.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      tok_in       = tok_ff;
      halted_in    = halted_ff;
      conv_hex_in  = conv_hex_ff;
      nz_in        = nz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      last_char_in = last_char_ff;
      du_cmd       = '{op: hdtc_pkg::DU_HOLD, serial_bit: acc_ff[VALUE_BITS-1]};
      du_load      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && !halted_ff) begin
               if (is_halt) begin
                  halted_in = 1'b1;
                  tok_in    = '0;
                  acc_in    = '0;
               end else if (req_chan.end_of_token) begin
                  tok_in = '0;
                  nz_in  = 1'b0;
                  du_cmd.op = hdtc_pkg::DU_LOAD;
                  if (tok_next.hex_mode) begin
                     acc_in      = acc_next;
                     conv_hex_in = 1'b0;
                     cnt_in      = CNT_W'(VALUE_BITS - 1);
                     state_in    = ST_DABBLE;
                  end else begin
                     du_load     = DIG_W'(acc_next);
                     acc_in      = '0;
                     conv_hex_in = 1'b1;
                     cnt_in      = CNT_W'(DEC_DIGITS - 1);
                     state_in    = ST_SKIP;
                  end
               end else begin
                  tok_in = tok_next;
                  acc_in = acc_next;
               end
            end
         end
         ST_DABBLE: begin
            du_cmd.op = hdtc_pkg::DU_DABBLE;
            acc_in    = acc_ff << 1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(DEC_DIGITS - 1);
               state_in = ST_SKIP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SKIP: begin
            // Digits above the last ten are shifted out and only set the nonzero flag.
            if (32'(cnt_ff) > 32'(hdtc_pkg::MAX_CHARS - 1)) begin
               nz_in     = nz_ff || top_nz;
               du_cmd.op = hdtc_pkg::DU_SHIFT;
               cnt_in    = cnt_ff - 1'b1;
            end else if (nz_ff || top_nz || (cnt_ff == '0)) begin
               if (conv_hex_ff && !nz_ff && (32'(cnt_ff) < 32'(hdtc_pkg::MAX_CHARS - 2))) begin
                  state_in = ST_PRE0;
               end else if (conv_hex_ff && !nz_ff
                            && (32'(cnt_ff) == 32'(hdtc_pkg::MAX_CHARS - 2))) begin
                  state_in = ST_PREX;
               end else begin
                  state_in = ST_DIGITS;
               end
            end else begin
               du_cmd.op = hdtc_pkg::DU_SHIFT;
               cnt_in    = cnt_ff - 1'b1;
            end
         end
         ST_PRE0: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_char_in  = hdtc_pkg::ASCII_ZERO;
               last_char_in = 1'b0;
               state_in     = ST_PREX;
            end
         end
         ST_PREX: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_char_in  = hdtc_pkg::ASCII_LOWER_X;
               last_char_in = 1'b0;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_char_in  = digit_char;
               last_char_in = (cnt_ff == '0);
               du_cmd.op    = hdtc_pkg::DU_SHIFT;
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tok_ff       <= '0;
         acc_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tok_ff       <= tok_in;
         acc_ff       <= acc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      conv_hex_ff  <= conv_hex_in;
      nz_ff        <= nz_in;
      out_char_ff  <= out_char_in;
      last_char_ff <= last_char_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = out_char_ff;
   assign rsp_chan.last_char = last_char_ff;

endmodule

`default_nettype wire
